// ===== rtl/core/sha256_stream_hasher_top_defines.svh =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top_defines.svh
// Assertion macros used by the hasher top RTL file.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA256_STREAM_HASHER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset
`define SHA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset
`define SHA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, initial hash values and round constants of the hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef logic [31:0] sha_word_t;

  // Working variables of the compression rounds
  typedef struct packed {
    sha_word_t a;
    sha_word_t b;
    sha_word_t c;
    sha_word_t d;
    sha_word_t e;
    sha_word_t f;
    sha_word_t g;
    sha_word_t h;
  } sha_vars_t;

  // Control of the message schedule shift line
  typedef struct packed {
    logic push;  // shift in a packed message word
    logic step;  // shift in the next expanded schedule word
  } sha_sched_ctrl_t;

  localparam sha_word_t SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constant for round idx
  function automatic sha_word_t sha_k(input logic [5:0] idx);
    sha_word_t k;
    case (idx)
      6'd0:  k = 32'h428a2f98;
      6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;
      6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;
      6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;
      6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;
      6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;
      6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;
      6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;
      6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;
      6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;
      6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;
      6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;
      6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;
      6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;
      6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;
      6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;
      6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;
      6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;
      6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;
      6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;
      6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;
      6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = 32'h00000000;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/core/sha_sched.sv =====
// ----------------------------------------------------------------------------
// sha_sched
// Message schedule: a sixteen-word shift line that takes packed message
// words and then expands them one word per round.
// ----------------------------------------------------------------------------
module sha_sched (
  input  logic                     clk,
  input  sha_pkg::sha_sched_ctrl_t ctrl,
  input  sha_pkg::sha_word_t       in_word,
  output sha_pkg::sha_word_t       w_cur
);
  import sha_pkg::*;

  sha_word_t w_r [16];
  sha_word_t w_new;
  sha_word_t sig0;
  sha_word_t sig1;

  // Small sigma functions on the fixed taps
  assign sig0 = {w_r[1][6:0], w_r[1][31:7]} ^ {w_r[1][17:0], w_r[1][31:18]}
              ^ {3'b000, w_r[1][31:3]};
  assign sig1 = {w_r[14][16:0], w_r[14][31:17]} ^ {w_r[14][18:0], w_r[14][31:19]}
              ^ {10'd0, w_r[14][31:10]};
  assign w_new = sig1 + w_r[9] + sig0 + w_r[0];

  assign w_cur = w_r[0];

  // Advance the line on a pushed word or a round step
  always_ff @(posedge clk) begin
    if (ctrl.push || ctrl.step) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[15] <= ctrl.step ? w_new : in_word;
    end
  end

endmodule

// ===== rtl/core/sha_round.sv =====
// ----------------------------------------------------------------------------
// sha_round
// One SHA-256 compression round, shared by all 64 rounds of a block.
// ----------------------------------------------------------------------------
module sha_round (
  input  sha_pkg::sha_vars_t v_in,
  input  sha_pkg::sha_word_t k,
  input  sha_pkg::sha_word_t w,
  output sha_pkg::sha_vars_t v_out
);
  import sha_pkg::*;

  sha_word_t big0;
  sha_word_t big1;
  sha_word_t ch;
  sha_word_t maj;
  sha_word_t t1;
  sha_word_t t2;

  // Big sigma, choose and majority
  assign big1 = {v_in.e[5:0], v_in.e[31:6]} ^ {v_in.e[10:0], v_in.e[31:11]}
              ^ {v_in.e[24:0], v_in.e[31:25]};
  assign big0 = {v_in.a[1:0], v_in.a[31:2]} ^ {v_in.a[12:0], v_in.a[31:13]}
              ^ {v_in.a[21:0], v_in.a[31:22]};
  assign ch   = (v_in.e & v_in.f) ^ (~v_in.e & v_in.g);
  assign maj  = (v_in.a & v_in.b) ^ (v_in.a & v_in.c) ^ (v_in.b & v_in.c);
  assign t1   = v_in.h + big1 + ch + k + w;
  assign t2   = big0 + maj;

  // Rotate the working variables
  always_comb begin
    v_out.h = v_in.g;
    v_out.g = v_in.f;
    v_out.f = v_in.e;
    v_out.e = v_in.d + t1;
    v_out.d = v_in.c;
    v_out.c = v_in.b;
    v_out.b = v_in.a;
    v_out.a = t1 + t2;
  end

endmodule

// ===== rtl/core/sha256_stream_hasher_top.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// Byte-stream SHA-256 hasher with one shared round unit.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one message byte per item in in_tdata and the
//   request kind in in_tuser: absorb, absorb then finish, or finish alone.
//   The out_ channel returns the eight digest words, most significant first,
//   with the word position beside each word and tlast on the eighth.
// Sequence:
//   An absorbed byte that does not fill the block leaves the hasher idle.
//   The byte that fills the 64-byte block starts the 64 rounds through the
//   single round unit, and the result is then folded into the chaining
//   state. A finish runs a set-up step, writes pad bytes up to the block
//   end, compresses and folds each padded block (two blocks when 56 or more
//   bytes are held) and then returns the eight output words.
//   in_tready is low while a block is compressed and throughout a finish.
// Reset:
//   rst_n low loads the initial hash values and clears the byte count and the
//   bit length; the block is ready as soon as reset is released.
// Stalls:
//   A digest word holds on out_tdata until it is taken; no new item is
//   accepted until the eighth word has gone.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_top_defines.svh"

module sha256_stream_hasher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        out_tlast   // last_word
);
  import sha_pkg::*;

  localparam logic [1:0] REQ_ABSORB     = 2'd0;
  localparam logic [1:0] REQ_ABSORB_FIN = 2'd1;
  localparam logic [1:0] REQ_FINISH     = 2'd2;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_COMP = 3'd1;
  localparam logic [2:0] ST_FOLD = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_PAD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  fill_r;
  logic [23:0] acc_r;
  logic [63:0] msg_bits_r;
  logic [63:0] len_r;
  logic        two_r;
  logic        first_r;
  logic        pad_mode_r;
  logic        fin_pend_r;
  logic [5:0]  rnd_r;
  logic [2:0]  oidx_r;
  sha_word_t   chain_r [8];
  sha_vars_t   v_r;
  sha_vars_t   v_round;
  sha_vars_t   v_chain;

  logic            in_acc;
  logic            out_acc;
  logic            is_absorb;
  logic            byte_wr;
  logic            block_full;
  logic            len_byte;
  logic [7:0]      pad_byte;
  logic [7:0]      byte_val;
  sha_word_t       w_cur;
  sha_sched_ctrl_t sched_ctrl;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == ST_OUT);
  assign out_acc    = out_tvalid && out_tready;
  assign out_tdata  = {5'd0, oidx_r, chain_r[0]};
  assign out_tlast  = (oidx_r == 3'd7);

  // Byte source: message bytes from the input, pad bytes from the sequencer
  assign is_absorb  = in_acc && ((in_tuser == REQ_ABSORB) || (in_tuser == REQ_ABSORB_FIN));
  assign len_byte   = !first_r && !two_r && (fill_r >= 6'd56);
  assign pad_byte   = first_r ? 8'h80 : (len_byte ? len_r[63:56] : 8'h00);
  assign byte_wr    = is_absorb || (state_r == ST_PAD);
  assign byte_val   = (state_r == ST_PAD) ? pad_byte : in_tdata;
  assign block_full = byte_wr && (fill_r == 6'd63);

  assign sched_ctrl.push = byte_wr && (fill_r[1:0] == 2'b11);
  assign sched_ctrl.step = (state_r == ST_COMP);

  sha_sched u_sched (
    .clk     (clk),
    .ctrl    (sched_ctrl),
    .in_word ({acc_r, byte_val}),
    .w_cur   (w_cur)
  );

  sha_round u_round (
    .v_in  (v_r),
    .k     (sha_k(rnd_r)),
    .w     (w_cur),
    .v_out (v_round)
  );

  assign v_chain = {chain_r[0], chain_r[1], chain_r[2], chain_r[3],
                    chain_r[4], chain_r[5], chain_r[6], chain_r[7]};

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            REQ_ABSORB:     state_nxt = block_full ? ST_COMP : ST_IDLE;
            REQ_ABSORB_FIN: state_nxt = block_full ? ST_COMP : ST_FIN;
            REQ_FINISH:     state_nxt = ST_FIN;
            default:        state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_COMP: begin
        if (rnd_r == 6'd63) state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        if (pad_mode_r) begin
          state_nxt = two_r ? ST_PAD : ST_OUT;
        end else begin
          state_nxt = fin_pend_r ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: state_nxt = ST_PAD;
      ST_PAD: begin
        if (block_full) state_nxt = ST_COMP;
      end
      ST_OUT: begin
        if (out_acc && out_tlast) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      fill_r     <= 6'd0;
      msg_bits_r <= 64'd0;
      two_r      <= 1'b0;
      first_r    <= 1'b0;
      pad_mode_r <= 1'b0;
      fin_pend_r <= 1'b0;
      rnd_r      <= 6'd0;
      oidx_r     <= 3'd0;
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= SHA_IV[i];
      end
    end else begin
      state_r <= state_nxt;
      if (byte_wr) fill_r <= fill_r + 6'd1;
      if (state_r == ST_COMP) rnd_r <= rnd_r + 6'd1;
      if (in_acc && (in_tuser == REQ_ABSORB_FIN) && block_full) fin_pend_r <= 1'b1;
      if (state_r == ST_FIN) begin
        fin_pend_r <= 1'b0;
        pad_mode_r <= 1'b1;
        first_r    <= 1'b1;
        two_r      <= (fill_r >= 6'd56);
      end
      if (state_r == ST_PAD) first_r <= 1'b0;
      // Fold the working variables into the chaining state
      if (state_r == ST_FOLD) begin
        chain_r[0] <= chain_r[0] + v_r.a;
        chain_r[1] <= chain_r[1] + v_r.b;
        chain_r[2] <= chain_r[2] + v_r.c;
        chain_r[3] <= chain_r[3] + v_r.d;
        chain_r[4] <= chain_r[4] + v_r.e;
        chain_r[5] <= chain_r[5] + v_r.f;
        chain_r[6] <= chain_r[6] + v_r.g;
        chain_r[7] <= chain_r[7] + v_r.h;
        if (pad_mode_r) begin
          two_r <= 1'b0;
        end else begin
          msg_bits_r <= msg_bits_r + 64'd512;
        end
      end
      // Shift the digest out and the initial vector back in
      if (out_acc) begin
        for (int i = 0; i < 7; i++) begin
          chain_r[i] <= chain_r[i + 1];
        end
        chain_r[7] <= SHA_IV[oidx_r];
        oidx_r     <= oidx_r + 3'd1;
        if (out_tlast) begin
          msg_bits_r <= 64'd0;
          pad_mode_r <= 1'b0;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (byte_wr) acc_r <= {acc_r[15:0], byte_val};
    if (state_r == ST_FIN) begin
      len_r <= msg_bits_r + {55'd0, fill_r, 3'd0};
    end else if ((state_r == ST_PAD) && len_byte) begin
      len_r <= {len_r[55:0], 8'h00};
    end
    if (state_r == ST_COMP) begin
      v_r <= v_round;
    end else if (state_nxt == ST_COMP) begin
      v_r <= v_chain;
    end
  end

  `SHA_ASSERT_IMP(a_ready_excl, in_tready, !out_tvalid,
                  "input ready while a digest word is pending")
  `SHA_ASSERT_IMP(a_last_index, out_tvalid && out_tlast, out_tdata[34:32] == 3'd7,
                  "last digest word not at position seven")
  `SHA_ASSERT_NXT(a_round_end, (state_r == ST_COMP) && (rnd_r == 6'd63),
                  (state_r == ST_FOLD) && (rnd_r == 6'd0),
                  "round sequence did not end in the fold")
  `SHA_ASSERT_NXT(a_finish_busy, in_acc && (in_tuser == REQ_FINISH), !in_tready,
                  "finish item did not hold off the input")
  `SHA_ASSERT_NXT(a_digest_done, out_acc && out_tlast,
                  in_tready && (fill_r == 6'd0) && (msg_bits_r == 64'd0) && !pad_mode_r,
                  "state not cleared after the digest")

endmodule

// ===== dv/sha_req_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_req_pkg
// Request codes carried on in_tuser, shared by the hasher stimulus and checker.
// ----------------------------------------------------------------------------
package sha_req_pkg;

  typedef enum logic [1:0] {
    REQ_ABSORB        = 2'd0,  // append the byte
    REQ_ABSORB_FINISH = 2'd1,  // append the byte, then pad and emit the digest
    REQ_FINISH        = 2'd2,  // pad and emit the digest, byte ignored
    REQ_UNUSED        = 2'd3   // spare code, no effect on the hasher
  } req_code_t;

endpackage

// ===== dv/sha256_digest_checker.sv =====
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches both streams of the hasher, runs its own SHA-256 on every accepted
// request and compares each digest word taken from the output in order.
// ----------------------------------------------------------------------------
module sha256_digest_checker
  import sha_req_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,        // [7:0] data_byte
  input  logic [1:0]  in_tuser,        // [1:0] req_type
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,       // [31:0] digest_word, [34:32] word_index
  input  logic        out_tlast,       // last_word
  output int          words_pending,
  output int          mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam bit [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct {
    bit [31:0] word;
    bit [2:0]  index;
    bit        last;
  } digest_word_t;

  digest_word_t expected_words [$];
  bit [31:0]    hash_state [8];
  bit [7:0]     block_bytes [64];
  int unsigned  bytes_held;
  bit [63:0]    length_bits;
  int           errors = 0;

  function automatic bit [31:0] rotr(bit [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Return the chaining state and counters to the start of a message
  function automatic void restart_message();
    hash_state  = START_HASH;
    bytes_held  = 0;
    length_bits = '0;
  endfunction

  // Fold the 64-byte block into the chaining state
  function automatic void compress_block();
    bit [31:0] w [64];
    bit [31:0] a, b, c, d, e, f, g, h;
    bit [31:0] s0, s1, t1, t2;
    int        i;
    for (i = 0; i < 16; i++) begin
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    for (i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    {a, b, c, d} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3]};
    {e, f, g, h} = {hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
    for (i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g;
      g = f;
      f = e;
      e = d + t1;
      d = c;
      c = b;
      b = a;
      a = t1 + t2;
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
    hash_state[4] += e;
    hash_state[5] += f;
    hash_state[6] += g;
    hash_state[7] += h;
  endfunction

  // Append one byte, compressing when the block is full
  function automatic void absorb_byte(bit [7:0] value);
    block_bytes[bytes_held] = value;
    bytes_held++;
    if (bytes_held == 64) begin
      compress_block();
      length_bits += 64'd512;
      bytes_held = 0;
    end
  endfunction

  // Pad, compress the tail block(s) and queue the eight digest words
  function automatic void finish_message();
    int        fill;
    int        i;
    int        k;
    bit [63:0] total;
    fill = bytes_held;
    i = fill;
    block_bytes[i] = 8'h80;
    i++;
    // no room for the length: pad out and spend an extra block
    if (fill >= 56) begin
      while (i < 64) begin
        block_bytes[i] = 8'h00;
        i++;
      end
      compress_block();
      i = 0;
    end
    while (i < 56) begin
      block_bytes[i] = 8'h00;
      i++;
    end
    total = length_bits + 64'(fill) * 64'd8;
    for (k = 0; k < 8; k++) block_bytes[56+k] = total[8*(7-k) +: 8];
    compress_block();
    for (k = 0; k < 8; k++) begin
      expected_words.push_back(digest_word_t'{hash_state[k], 3'(k), k == 7});
    end
    restart_message();
  endfunction

  function automatic void take_request(req_code_t kind, bit [7:0] value);
    case (kind)
      REQ_ABSORB: begin
        absorb_byte(value);
      end
      REQ_ABSORB_FINISH: begin
        absorb_byte(value);
        finish_message();
      end
      REQ_FINISH: begin
        finish_message();
      end
      default: begin
      end
    endcase
  endfunction

  // Compare one output item against the oldest outstanding digest word
  function automatic void check_word(bit [31:0] word, bit [2:0] index, bit last);
    digest_word_t want;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected digest word %h index %0d last %0b",
               $time, word, index, last);
      errors++;
      return;
    end
    want = expected_words.pop_front();
    if (word !== want.word || index !== want.index || last !== want.last) begin
      $display("%0t: digest word expected %h index %0d last %0b, actual %h index %0d last %0b",
               $time, want.word, want.index, want.last, word, index, last);
      errors++;
    end
  endfunction

  // Track both channels on every rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      restart_message();
      expected_words.delete();
    end else begin
      if (in_tvalid && in_tready) take_request(req_code_t'(in_tuser), in_tdata);
      if (out_tvalid && out_tready) check_word(out_tdata[31:0], out_tdata[34:32], out_tlast);
    end
    words_pending  <= expected_words.size();
    mismatch_count <= errors;
  end

endmodule

// ===== dv/tb_sha256_stream_hasher_top.sv =====
// ----------------------------------------------------------------------------
// tb_sha256_stream_hasher_top
// Drives byte messages into the SHA-256 hasher: a few fixed messages (empty,
// single bytes, "abc", spare request codes), then random messages whose
// lengths favour the padding boundaries, with random gaps on both streams and
// one long output stall. The checker beside the block judges every word.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sha_req_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 600;
  localparam int HOLD_AT_WORD   = 48;
  localparam int DRAIN_CYCLES   = 150;
  localparam int RANDOM_ITEMS   = 250;
  localparam int RANDOM_DIGESTS = 8;
  localparam int BOUNDARY_LEN [6] = '{55, 56, 63, 64, 65, 120};

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic [1:0]  in_tuser   = 2'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;

  int words_pending;
  int mismatch_count;
  int idle_cycles  = 0;
  int send_burst   = 0;
  int take_burst   = 0;
  int words_taken  = 0;
  int items_sent   = 0;
  int digests_sent = 0;

  sha256_stream_hasher_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  sha256_digest_checker digest_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .words_pending  (words_pending),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Gap before the next item: mostly 0..19, with occasional runs of no gap
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      burst = $urandom_range(5, 40);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // Random byte with the all-zero and all-one extremes weighted up
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int pick_length();
    if ($urandom_range(0, 9) < 4) return BOUNDARY_LEN[$urandom_range(0, 5)];
    return $urandom_range(0, 20);
  endfunction

  // Offer one item and hold it until the block takes it
  task automatic send_item(req_code_t kind, logic [7:0] value);
    int gap;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Send a whole message, ending it either on its last byte or with a bare finish
  task automatic send_message(int len);
    int k;
    if (len == 0) begin
      send_item(REQ_FINISH, pick_byte());
      items_sent++;
    end else begin
      for (k = 0; k < len - 1; k++) begin
        if ($urandom_range(0, 31) == 0) send_item(REQ_UNUSED, pick_byte());
        send_item(REQ_ABSORB, pick_byte());
      end
      if ($urandom_range(0, 1) == 1) begin
        send_item(REQ_ABSORB_FINISH, pick_byte());
        items_sent += len;
      end else begin
        send_item(REQ_ABSORB, pick_byte());
        send_item(REQ_FINISH, pick_byte());
        items_sent += len + 1;
      end
    end
    digests_sent++;
  endtask

  // Stimulus and verdict
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty messages, one of them behind a spare request code
    send_item(REQ_FINISH, 8'hff);
    send_item(REQ_UNUSED, 8'h5a);
    send_item(REQ_FINISH, 8'h00);
    // single-byte messages at both extremes
    send_item(REQ_ABSORB_FINISH, 8'h00);
    send_item(REQ_ABSORB_FINISH, 8'hff);
    // "abc" with a spare code in the middle
    send_item(REQ_ABSORB, 8'h61);
    send_item(REQ_ABSORB, 8'h62);
    send_item(REQ_UNUSED, 8'ha5);
    send_item(REQ_ABSORB_FINISH, 8'h63);
    // two bytes then a bare finish
    send_item(REQ_ABSORB, 8'hff);
    send_item(REQ_ABSORB, 8'h00);
    send_item(REQ_FINISH, 8'hff);

    while (items_sent < RANDOM_ITEMS || digests_sent < RANDOM_DIGESTS) begin
      send_message(pick_length());
    end
    in_tvalid <= 1'b0;

    // wait for the checker to see the last request, then for every digest word
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && words_pending == 0) begin
      $display("sha256_stream_hasher_top: match");
    end else begin
      $display("sha256_stream_hasher_top: mismatch");
    end
    $finish;
  end

  // Take digest words with random stalls, and one long hold-off on a waiting digest
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (words_taken == HOLD_AT_WORD) begin
        out_tready <= 1'b0;
        @(posedge clk);
        while (!out_tvalid) @(posedge clk);
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        gap = draw_gap(take_burst);
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      words_taken++;
    end
  end

  // Abort when neither channel has moved an item for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sha256_stream_hasher_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/sha_pkg.sv
rtl/core/sha_sched.sv
rtl/core/sha_round.sv
rtl/core/sha256_stream_hasher_top.sv
dv/sha_req_pkg.sv
dv/sha256_digest_checker.sv
dv/tb_sha256_stream_hasher_top.sv
